@@ hw/rtl/i2c_mra_pkg.sv @@
// Shared types and constants for the I2C master register access core.
package i2c_mra_pkg;

    localparam int COUNT_WIDTH = 16;
    // Largest phase length that the phase timer can count to.
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd255;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_BEGIN_WR   = 2'd1;
    localparam logic [1:0] OP_BEGIN_RD   = 2'd2;
    localparam logic [1:0] OP_NEXT_BYTE  = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } i2c_mra_in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       write_request;
        logic       nack_seen;
        logic       busy_res;
        logic       done_res;
    } i2c_mra_out_t;

endpackage

@@ hw/rtl/i2c_mra_seq.sv @@
// Bit sequencer: transaction state, phase timer and line levels for one tick item.
module i2c_mra_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  i2c_mra_pkg::i2c_mra_in_t   item,
    input  logic [15:0]                half_period,
    output i2c_mra_pkg::i2c_mra_out_t  result
);
    import i2c_mra_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_STA_A, ST_STA_B, ST_TX_LO, ST_TX_HI, ST_ACK_LO, ST_ACK_HI,
        ST_WAIT, ST_RS_LO, ST_RX_LO, ST_RX_HI, ST_RK_LO, ST_RK_HI,
        ST_STP_A, ST_STP_B, ST_STP_C
    } step_t;

    typedef enum logic [1:0] {
        KIND_ADDR_W, KIND_REG, KIND_DATA, KIND_ADDR_R
    } kind_t;

    step_t                  step_reg, step_next;
    kind_t                  kind_reg, kind_next;
    logic [3:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic [7:0]             left_reg, left_next;
    logic [COUNT_WIDTH-1:0] phase_reg, phase_next;
    logic [6:0]             addr_reg, addr_next;
    logic [7:0]             ptr_reg, ptr_next;
    logic                   rd_reg, rd_next;
    logic                   nack_reg, nack_next;

    logic [COUNT_WIDTH-1:0] target;
    logic [COUNT_WIDTH-1:0] phase_inc;
    logic [31:0]            half_period_wide;
    logic                   busy;
    logic                   wreq;

    // A zero half period behaves as one tick; a longer one saturates at the timer range.
    assign half_period_wide = 32'(half_period);
    assign target = (half_period == '0) ? COUNT_WIDTH'(1) :
                    (half_period_wide > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX) :
                    COUNT_WIDTH'(half_period_wide);

    always_comb begin
        step_next  = step_reg;
        kind_next  = kind_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        phase_next = phase_reg;
        addr_next  = addr_reg;
        ptr_next   = ptr_reg;
        rd_next    = rd_reg;
        nack_next  = nack_reg;
        result     = '0;
        phase_inc  = '0;

        if (step_reg == ST_IDLE &&
            (item.operation == OP_BEGIN_WR || item.operation == OP_BEGIN_RD)) begin
            addr_next  = item.device_address;
            ptr_next   = item.register_address;
            left_next  = item.byte_count;
            rd_next    = (item.operation == OP_BEGIN_RD);
            nack_next  = 1'b0;
            kind_next  = KIND_ADDR_W;
            bit_next   = '0;
            shift_next = '0;
            phase_next = '0;
            step_next  = ST_STA_A;
        end else if (step_reg == ST_WAIT && item.operation == OP_NEXT_BYTE) begin
            kind_next  = KIND_DATA;
            shift_next = item.write_data;
            bit_next   = '0;
            phase_next = '0;
            step_next  = ST_TX_LO;
        end

        // Line levels follow the state as it stands before this tick's phase ends.
        result.scl_out = (step_next == ST_IDLE || step_next == ST_STA_A ||
                          step_next == ST_STA_B || step_next == ST_TX_HI ||
                          step_next == ST_ACK_HI || step_next == ST_RX_HI ||
                          step_next == ST_RK_HI || step_next == ST_STP_B ||
                          step_next == ST_STP_C);
        if (step_next == ST_STA_B || step_next == ST_STP_A || step_next == ST_STP_B) begin
            result.sda_out = 1'b0;
        end else if (step_next == ST_TX_LO || step_next == ST_TX_HI) begin
            result.sda_out = shift_next[7];
        end else if (step_next == ST_RK_LO || step_next == ST_RK_HI) begin
            result.sda_out = (left_next == 8'd1);
        end else begin
            result.sda_out = 1'b1;
        end

        busy = (step_next != ST_IDLE);
        wreq = (step_next == ST_WAIT);
        result.busy_res      = busy;
        result.write_request = wreq;

        if (busy && !wreq) begin
            phase_inc = phase_next + COUNT_WIDTH'(1);
            if (phase_inc >= target) begin
                phase_next = '0;
                case (step_next)
                    ST_STA_A: begin
                        step_next = ST_STA_B;
                    end
                    ST_STA_B: begin
                        shift_next = {addr_next, (kind_next == KIND_ADDR_R)};
                        bit_next   = '0;
                        step_next  = ST_TX_LO;
                    end
                    ST_TX_LO: begin
                        step_next = ST_TX_HI;
                    end
                    ST_TX_HI: begin
                        shift_next = {shift_next[6:0], 1'b0};
                        bit_next   = bit_next + 4'd1;
                        step_next  = (bit_next >= 4'd8) ? ST_ACK_LO : ST_TX_LO;
                    end
                    ST_ACK_LO: begin
                        step_next = ST_ACK_HI;
                    end
                    ST_ACK_HI: begin
                        if (item.sda_in) begin
                            nack_next = 1'b1;
                        end
                        case (kind_next)
                            KIND_ADDR_W: begin
                                kind_next  = KIND_REG;
                                shift_next = ptr_next;
                                bit_next   = '0;
                                step_next  = ST_TX_LO;
                            end
                            KIND_REG: begin
                                if (rd_next) begin
                                    kind_next = KIND_ADDR_R;
                                    step_next = ST_RS_LO;
                                end else begin
                                    step_next = (left_next == '0) ? ST_STP_A : ST_WAIT;
                                end
                            end
                            KIND_DATA: begin
                                left_next = left_next - 8'd1;
                                step_next = (left_next == '0) ? ST_STP_A : ST_WAIT;
                            end
                            default: begin
                                bit_next   = '0;
                                shift_next = '0;
                                step_next  = (left_next == '0) ? ST_STP_A : ST_RX_LO;
                            end
                        endcase
                    end
                    ST_RS_LO: begin
                        step_next = ST_STA_A;
                    end
                    ST_RX_LO: begin
                        step_next = ST_RX_HI;
                    end
                    ST_RX_HI: begin
                        shift_next = {shift_next[6:0], item.sda_in};
                        bit_next   = bit_next + 4'd1;
                        if (bit_next >= 4'd8) begin
                            result.read_data  = shift_next;
                            result.read_valid = 1'b1;
                            result.read_last  = (left_next == 8'd1);
                            step_next         = ST_RK_LO;
                        end else begin
                            step_next = ST_RX_LO;
                        end
                    end
                    ST_RK_LO: begin
                        step_next = ST_RK_HI;
                    end
                    ST_RK_HI: begin
                        left_next  = left_next - 8'd1;
                        bit_next   = '0;
                        shift_next = '0;
                        step_next  = (left_next == '0) ? ST_STP_A : ST_RX_LO;
                    end
                    ST_STP_A: begin
                        step_next = ST_STP_B;
                    end
                    ST_STP_B: begin
                        step_next = ST_STP_C;
                    end
                    ST_STP_C: begin
                        step_next       = ST_IDLE;
                        result.done_res = 1'b1;
                    end
                    default: begin
                        step_next = ST_IDLE;
                    end
                endcase
            end else begin
                phase_next = phase_inc;
            end
        end

        result.nack_seen = nack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= ST_IDLE;
            kind_reg  <= KIND_ADDR_W;
            bit_reg   <= '0;
            shift_reg <= '0;
            left_reg  <= '0;
            phase_reg <= '0;
            addr_reg  <= '0;
            ptr_reg   <= '0;
            rd_reg    <= 1'b0;
            nack_reg  <= 1'b0;
        end else if (advance) begin
            step_reg  <= step_next;
            kind_reg  <= kind_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            ptr_reg   <= ptr_next;
            rd_reg    <= rd_next;
            nack_reg  <= nack_next;
        end
    end

    // The bit counter never runs past one byte.
    assert property (@(posedge aclk) disable iff (!aresetn) bit_reg <= 4'd8)
        else $error("bit counter out of range");

    // The phase timer stays below the phase length while a phase is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && $past(advance) && $stable(half_period) && step_reg != ST_IDLE
        |-> phase_reg < target)
        else $error("phase timer overran its target");

endmodule

@@ hw/rtl/i2c_master_register_access_core.sv @@
// Top level of the I2C master register access core: handshakes, config and result register.
// Latency: a result item appears on m_data in the cycle after its tick item is accepted.
// Throughput: one tick item per cycle; s_ready drops only while the result register
// holds an item that the consumer has not taken (s_ready = !m_valid || m_ready).
// Reset (aresetn low, synchronous): sequencer idle, no result pending, half_period
// back to 255.
module i2c_master_register_access_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  i2c_mra_pkg::i2c_mra_in_t  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output i2c_mra_pkg::i2c_mra_out_t m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [15:0]               cfg_data
);
    import i2c_mra_pkg::*;

    logic [15:0]  half_period_reg;
    logic         m_valid_reg;
    i2c_mra_out_t m_data_reg;
    i2c_mra_out_t seq_result;
    logic         accept;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    i2c_mra_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .item        (s_data),
        .half_period (half_period_reg),
        .result      (seq_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_valid) begin
            half_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= seq_result;
        end
    end

    // A finished stop still counts as part of the transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.busy_res)
        else $error("done without busy");

    // While waiting for a write byte, SCL is held low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.write_request |-> !m_data.scl_out && m_data.busy_res)
        else $error("waiting for a byte with SCL released");

    // A received byte completes on a high SCL phase and never marks last alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.read_valid || m_data.read_last)
        |-> m_data.read_valid && m_data.scl_out && !m_data.write_request)
        else $error("inconsistent read result");

endmodule
